// ----- hw/rtl/decimal_digit_bucket_distributor_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the decimal digit bucket distributor.
// Each macro checks a property on the rising clock edge while reset is off.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_BUCKET_DISTRIBUTOR_TOP_DEFINES_SVH
`define DECIMAL_DIGIT_BUCKET_DISTRIBUTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define DDBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ddbd assertion failed");
`define DDBD_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ddbd forbidden condition seen");
`else
`define DDBD_ASSERT(label, clk, rst_n, prop)
`define DDBD_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- hw/rtl/ddbd_pkg.sv -----
// ---------------------------------------------------------------------------
// ddbd_pkg
// Types and constants shared by the decimal digit bucket distributor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddbd_pkg;

    localparam int VALUE_W          = 16;
    localparam int STORE_DEPTH      = 64;
    localparam int ADDR_W           = 6;
    localparam int COUNT_W          = 7;
    localparam int NUM_BUCKETS      = 10;
    localparam int BUCKET_W         = 4;
    localparam int DEFAULT_CAPACITY = 64;

    // Division by ten through a reciprocal: (v * 0xCCCD) >> 19 is exact for 16 bits.
    localparam int PROD_W      = 32;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [VALUE_W-1:0] RECIP_TEN = 16'hCCCD;

    localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ADDR_W-1:0]  link;
    } entry_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        entry_t              wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic                valid;
        logic [VALUE_W-1:0]  value;
        logic                last;
        logic [BUCKET_W-1:0] digit;
    } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ddbd_in_if.sv -----
// ---------------------------------------------------------------------------
// ddbd_in_if
// Input channel: one value per transaction, with a last marker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddbd_in_if;
    logic                            valid;
    logic                            ready;
    logic [ddbd_pkg::VALUE_W-1:0]    value;
    logic                            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ddbd_out_if.sv -----
// ---------------------------------------------------------------------------
// ddbd_out_if
// Output channel: one reordered value per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddbd_out_if;
    logic                            valid;
    logic                            ready;
    logic [ddbd_pkg::VALUE_W-1:0]    value_res;
    logic                            last_res;
    logic                            overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                     input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                     output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ddbd_entry_mem.sv -----
// ---------------------------------------------------------------------------
// ddbd_entry_mem
// Entry store: value and bucket link per entry, one write and one
// registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddbd_entry_mem (
    input  wire logic               clk,
    input  wire ddbd_pkg::mem_req_t req,
    output ddbd_pkg::entry_t        rdata
);

    ddbd_pkg::entry_t mem [ddbd_pkg::STORE_DEPTH];
    ddbd_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ddbd_digit_stage.sv -----
// ---------------------------------------------------------------------------
// ddbd_digit_stage
// Input register that finds the last decimal digit of each value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddbd_digit_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ddbd_in_if.sink              in_ch,
    input  wire logic            load_ready,
    output ddbd_pkg::item_t      item
);

    logic                                 valid_reg;
    logic [ddbd_pkg::VALUE_W-1:0]         value_reg;
    logic                                 last_reg;
    logic [ddbd_pkg::QUOT_W-1:0]          quot_reg;
    logic [ddbd_pkg::PROD_W-1:0]          prod;
    logic [ddbd_pkg::VALUE_W-1:0]         quot_x10;
    logic [ddbd_pkg::VALUE_W-1:0]         rem_wide;

    assign in_ch.ready = load_ready;
    assign prod = ddbd_pkg::PROD_W'(in_ch.value) * ddbd_pkg::PROD_W'(ddbd_pkg::RECIP_TEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            value_reg <= '0;
            last_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            valid_reg <= in_ch.valid && load_ready;
            if (in_ch.valid && load_ready)
            begin
                value_reg <= in_ch.value;
                last_reg  <= in_ch.last;
                quot_reg  <= prod[ddbd_pkg::PROD_W-1:ddbd_pkg::RECIP_SHIFT];
            end
        end
    end

    assign quot_x10 = (ddbd_pkg::VALUE_W'(quot_reg) << 3) + (ddbd_pkg::VALUE_W'(quot_reg) << 1);
    assign rem_wide = value_reg - quot_x10;

    assign item.valid = valid_reg;
    assign item.value = value_reg;
    assign item.last  = last_reg;
    assign item.digit = rem_wide[ddbd_pkg::BUCKET_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/ddbd_bucket_ctrl.sv -----
// ---------------------------------------------------------------------------
// ddbd_bucket_ctrl
// Bucket heads, fill count and the sequencer that links entries on load
// and walks the buckets on emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_digit_bucket_distributor_top_defines.svh"

module ddbd_bucket_ctrl #(
    parameter int CAPACITY = ddbd_pkg::DEFAULT_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ddbd_pkg::item_t    item,
    output logic                    load_ready,
    output ddbd_pkg::mem_req_t      mem_req,
    input  wire ddbd_pkg::entry_t   rdata,
    ddbd_out_if.source              out_ch
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DATA
    } state_t;

    localparam logic [ddbd_pkg::COUNT_W-1:0] CAP_COUNT = ddbd_pkg::COUNT_W'(CAPACITY);
    localparam logic [ddbd_pkg::COUNT_W-1:0] ONE_COUNT = ddbd_pkg::COUNT_W'(1);

    state_t                              state_reg, state_next;
    logic [ddbd_pkg::BUCKET_W-1:0]       bucket_reg, bucket_next;
    logic [ddbd_pkg::ADDR_W-1:0]         cur_idx_reg, cur_idx_next;
    logic [ddbd_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [ddbd_pkg::COUNT_W-1:0]        remaining_reg, remaining_next;
    logic                                dropped_reg, dropped_next;
    logic [ddbd_pkg::NUM_BUCKETS-1:0]    head_valid_reg, head_valid_next;
    logic [ddbd_pkg::ADDR_W-1:0]         head_idx_reg [ddbd_pkg::NUM_BUCKETS];
    logic [ddbd_pkg::ADDR_W-1:0]         head_idx_next [ddbd_pkg::NUM_BUCKETS];
    logic                                out_valid_reg, out_valid_next;
    logic [ddbd_pkg::VALUE_W-1:0]        out_value_reg, out_value_next;
    logic                                out_last_reg, out_last_next;
    logic                                out_ovf_reg, out_ovf_next;
    logic                                full;
    logic                                out_free;

    assign full       = count_reg >= CAP_COUNT;
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign load_ready = (state_reg == ST_LOAD) && !(item.valid && item.last);

    always_comb
    begin
        state_next      = state_reg;
        bucket_next     = bucket_reg;
        cur_idx_next    = cur_idx_reg;
        count_next      = count_reg;
        remaining_next  = remaining_reg;
        dropped_next    = dropped_reg;
        head_valid_next = head_valid_reg;
        head_idx_next   = head_idx_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        mem_req         = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item.valid)
                begin
                    if (!full)
                    begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = count_reg[ddbd_pkg::ADDR_W-1:0];
                        mem_req.wdata.value = item.value;
                        mem_req.wdata.link  = head_valid_reg[item.digit]
                                            ? head_idx_reg[item.digit]
                                            : count_reg[ddbd_pkg::ADDR_W-1:0];
                        head_valid_next[item.digit] = 1'b1;
                        head_idx_next[item.digit]   = count_reg[ddbd_pkg::ADDR_W-1:0];
                        count_next = count_reg + ONE_COUNT;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        remaining_next = full ? count_reg : count_reg + ONE_COUNT;
                        bucket_next    = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (head_valid_reg[bucket_reg])
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = head_idx_reg[bucket_reg];
                    cur_idx_next  = head_idx_reg[bucket_reg];
                    state_next    = ST_DATA;
                end
                else if (bucket_reg == ddbd_pkg::LAST_BUCKET)
                begin
                    head_valid_next = '0;
                    count_next      = '0;
                    state_next      = ST_LOAD;
                end
                else
                begin
                    bucket_next = bucket_reg + 1'b1;
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rdata.value;
                    out_last_next  = (remaining_reg == ONE_COUNT);
                    out_ovf_next   = dropped_reg;
                    remaining_next = remaining_reg - ONE_COUNT;
                    if (remaining_reg == ONE_COUNT)
                    begin
                        head_valid_next = '0;
                        count_next      = '0;
                        state_next      = ST_LOAD;
                    end
                    else if (rdata.link != cur_idx_reg)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = rdata.link;
                        cur_idx_next  = rdata.link;
                    end
                    else
                    begin
                        bucket_next = bucket_reg + 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            bucket_reg     <= '0;
            cur_idx_reg    <= '0;
            count_reg      <= '0;
            remaining_reg  <= '0;
            dropped_reg    <= 1'b0;
            head_valid_reg <= '0;
            head_idx_reg   <= '{default: '0};
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bucket_reg     <= bucket_next;
            cur_idx_reg    <= cur_idx_next;
            count_reg      <= count_next;
            remaining_reg  <= remaining_next;
            dropped_reg    <= dropped_next;
            head_valid_reg <= head_valid_next;
            head_idx_reg   <= head_idx_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.value_res = out_value_reg;
    assign out_ch.last_res  = out_last_reg;
    assign out_ch.overflow  = out_ovf_reg;

    `DDBD_ASSERT(a_drop_sets_flag, clk, rst_n,
        (state_reg == ST_LOAD && item.valid && full) |=> dropped_reg)
    `DDBD_ASSERT(a_final_empties_store, clk, rst_n,
        (state_reg == ST_DATA && out_free && remaining_reg == ONE_COUNT)
        |=> (state_reg == ST_LOAD && count_reg == '0 && out_last_reg))
    `DDBD_ASSERT_NEVER(a_walk_without_entries, clk, rst_n,
        state_reg != ST_LOAD && remaining_reg == '0)
    `DDBD_ASSERT_NEVER(a_count_over_capacity, clk, rst_n,
        count_reg > CAP_COUNT)

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_digit_bucket_distributor_top.sv -----
// ---------------------------------------------------------------------------
// decimal_digit_bucket_distributor_top
// One radix sort pass on the last decimal digit of a stream of values.
//
// The in_ch channel takes one value per transaction. Values are linked
// newest first into ten buckets by value mod 10 and kept in a 64-entry
// store, one per cycle. A transaction with last set ends the sequence.
// The block then stops taking input and walks the buckets 0 to 9, each
// newest first, and presents every stored value on out_ch; last_res marks
// the final one and overflow tells whether any value was dropped because
// CAPACITY values were already stored. The overflow flag is sticky until
// reset.
// After the last transaction the emission gives one value per cycle inside
// a bucket while out_ch is ready, with a scan step for each bucket that is
// entered or skipped; the bucket walk follows the link read from the store,
// whose read data are registered and arrive in the cycle after the address.
// When out_ch stalls, the walk holds on the pending value. Reset empties all
// buckets and clears the overflow flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_bucket_distributor_top #(
    parameter int CAPACITY = ddbd_pkg::DEFAULT_CAPACITY
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ddbd_in_if.sink      in_ch,
    ddbd_out_if.source   out_ch
);

    ddbd_pkg::item_t     item;
    ddbd_pkg::mem_req_t  mem_req;
    ddbd_pkg::entry_t    rdata;
    logic                load_ready;

    ddbd_digit_stage u_digit_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .load_ready (load_ready),
        .item       (item)
    );

    ddbd_entry_mem u_entry_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    ddbd_bucket_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_bucket_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .load_ready (load_ready),
        .mem_req    (mem_req),
        .rdata      (rdata),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ----- tb/sv/decimal_digit_bucket_distributor_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_digit_bucket_distributor_top_tb
// Self-checking bench for one radix sort pass on the last decimal digit.
// A scripted table covers single values, the extremes of the value range,
// every digit and repeated digits. Random sequences follow, among them one
// that fills the store exactly and one that runs past capacity to raise the
// sticky overflow flag. A bucket-order model, or the result of a typed row,
// predicts each output transaction, compared field by field in arrival
// order. Inputs and outputs pause at random in the first two of three phases.
// ---------------------------------------------------------------------------

module decimal_digit_bucket_distributor_top_tb;

    localparam int STORE_CAP    = ddbd_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [ddbd_pkg::VALUE_W-1:0] value;
        logic                         last;
        logic                         ovf;
    } result_t;

    typedef struct packed {
        logic [ddbd_pkg::VALUE_W-1:0] value;
        logic                         last;
        logic                         typed;
        result_t                      res;
    } row_t;

    logic clk;
    logic rst_n;

    ddbd_in_if  in_ch ();
    ddbd_out_if out_ch ();

    decimal_digit_bucket_distributor_top #(
        .CAPACITY(STORE_CAP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [ddbd_pkg::VALUE_W-1:0] held_values[$];
    logic               overflow_seen;
    result_t            pass_batch[$];
    result_t            reordered_due[$];
    row_t               script[$];
    result_t            due_now;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned seqs_sent;
    int unsigned results_checked;
    int unsigned error_count;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic void bucket_pass(input logic [ddbd_pkg::VALUE_W-1:0] v, input logic l);
        int unsigned emitted;
        int unsigned total;
        result_t     r;
        pass_batch.delete();
        if (held_values.size() >= STORE_CAP)
            overflow_seen = 1'b1;
        else
            held_values.push_back(v);
        if (!l)
            return;
        emitted = 0;
        total   = held_values.size();
        for (int d = 0; d < ddbd_pkg::NUM_BUCKETS; d++)
        begin
            for (int i = held_values.size() - 1; i >= 0; i--)
            begin
                if (held_values[i] % ddbd_pkg::NUM_BUCKETS == d)
                begin
                    emitted++;
                    r.value = held_values[i];
                    r.last  = (emitted == total);
                    r.ovf   = overflow_seen;
                    pass_batch.push_back(r);
                end
            end
        end
        held_values.delete();
    endfunction

    function automatic void add_row(input logic [ddbd_pkg::VALUE_W-1:0] v, input logic l,
                                    input logic typed,
                                    input logic [ddbd_pkg::VALUE_W-1:0] rv,
                                    input logic rl, input logic ro);
        row_t r;
        r.value     = v;
        r.last      = l;
        r.typed     = typed;
        r.res.value = rv;
        r.res.last  = rl;
        r.res.ovf   = ro;
        script.push_back(r);
    endfunction

    function automatic logic [ddbd_pkg::VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return ddbd_pkg::VALUE_W'($urandom_range(65535));
        else if (sel < 85)
            return ddbd_pkg::VALUE_W'($urandom_range(99));
        else
            return ddbd_pkg::VALUE_W'($urandom_range(65535, 65436));
    endfunction

    task automatic send_item(input row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= r.value;
        in_ch.last  <= r.last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bucket_pass(r.value, r.last);
        if (r.typed)
            reordered_due.push_back(r.res);
        else
            foreach (pass_batch[k])
                reordered_due.push_back(pass_batch[k]);
        items_sent++;
        if (r.last)
            seqs_sent++;
        @(negedge clk);
    endtask

    task automatic send_sequence(input int unsigned len);
        row_t r;
        for (int unsigned i = 1; i <= len; i++)
        begin
            r       = '0;
            r.value = pick_value();
            r.last  = (i == len);
            send_item(r);
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_checked++;
            if (reordered_due.size() == 0)
            begin
                $error("unexpected transaction: value_res=%0d last_res=%0b overflow=%0b",
                       out_ch.value_res, out_ch.last_res, out_ch.overflow);
                error_count++;
            end
            else
            begin
                due_now = reordered_due.pop_front();
                if (out_ch.value_res !== due_now.value)
                begin
                    $error("value_res: expected %0d, got %0d", due_now.value, out_ch.value_res);
                    error_count++;
                end
                if (out_ch.last_res !== due_now.last)
                begin
                    $error("last_res: expected %0b, got %0b", due_now.last, out_ch.last_res);
                    error_count++;
                end
                if (out_ch.overflow !== due_now.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", due_now.ovf, out_ch.overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out with %0d transactions still expected.", reordered_due.size());
            $display("decimal_digit_bucket_distributor_top_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned len;
        int unsigned phase;
        bit          full_done;
        bit          over_done;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.value   = '0;
        in_ch.last    = 1'b0;
        overflow_seen = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 76;
        items_sent      = 0;
        seqs_sent       = 0;
        results_checked = 0;
        error_count     = 0;
        cycle_count     = 0;
        full_done       = 1'b0;
        over_done       = 1'b0;

        add_row(16'd0,     1'b1, 1'b1, 16'd0,     1'b1, 1'b0);
        add_row(16'd65535, 1'b1, 1'b1, 16'd65535, 1'b1, 1'b0);
        add_row(16'd1,     1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd65534, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd10,    1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd20,    1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd9,     1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd32768, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd21,    1'b1, 1'b0, '0, 1'b0, 1'b0);
        for (int d = ddbd_pkg::NUM_BUCKETS - 1; d >= 0; d--)
            add_row(ddbd_pkg::VALUE_W'(65530 - 10 * d + d), d == 0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd42,    1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd42,    1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(16'd43690, 1'b1, 1'b1, 16'd43690, 1'b1, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_item(script[i]);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            phase = random_sent * 3 / RANDOM_ITEMS;
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 16 : 0;
            if (phase == 1 && !full_done)
            begin
                len = STORE_CAP;
                full_done = 1'b1;
            end
            else if (phase == 2 && !over_done && random_sent > RANDOM_ITEMS * 3 / 4)
            begin
                len = STORE_CAP + $urandom_range(6, 1);
                over_done = 1'b1;
            end
            else if ($urandom_range(9) == 0)
                len = 1;
            else
                len = $urandom_range(16, 2);
            send_sequence(len);
            random_sent += len;
        end
        in_ch.valid <= 1'b0;

        while (reordered_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input transactions in %0d sequences; %0d output transactions checked.",
                 items_sent, seqs_sent, results_checked);
        $display("Covered full store, overflow drop and sticky flag under three pause patterns.");
        if (error_count == 0)
            $display("decimal_digit_bucket_distributor_top_tb: PASS");
        else
            $display("decimal_digit_bucket_distributor_top_tb: FAIL");
        $finish;
    end

endmodule
